// ===== src/assert_macros.svh =====
// Assertion helpers used by the trajectory unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clk.
`define MQT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on the rising edge of clk.
`define MQT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/mqt_pkg.sv =====
package mqt_pkg;

  // Input operation codes carried on tuser.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Q1.24 unity for the normalised time.
  localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;

  // Polynomial coefficients of s(tau) and its derivative.
  localparam logic signed [31:0] C6  = 32'sd6;
  localparam logic signed [31:0] C10 = 32'sd10;
  localparam logic signed [31:0] C15 = 32'sd15;
  localparam logic signed [31:0] C30 = 32'sd30;
  localparam logic signed [31:0] C60 = 32'sd60;

  // One evaluation request for the serial unit.
  typedef struct packed {
    logic [31:0] start_pos;
    logic [31:0] end_pos;
    logic [15:0] dur;
    logic [15:0] elap;
  } req_t;

  // Evaluated target for one axis.
  typedef struct packed {
    logic [31:0] position;
    logic [31:0] velocity;
  } res_t;

endpackage

// ===== src/multi_axis_quintic_trajectory_unit.sv =====
// Quintic point-to-point trajectory generator for up to AXIS_COUNT axes. A start transfer
// loads one axis and a stop transfer deactivates it. A tick transfer advances every active
// axis, re-evaluates its position and velocity, and then sends one result per axis in
// order, the final one marked by out_tlast. Evaluation runs through one shared bit-serial
// unit: a restoring divider and a shift-add multiplier. An inactive axis skips the unit,
// and output back-pressure holds the sequence. A new input transfer is taken once the
// previous tick has handed its final result to the output register.
`include "assert_macros.svh"

module multi_axis_quintic_trajectory_unit
  import mqt_pkg::*;
#(
  parameter int AXIS_COUNT = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  // Fields from bit 0: axis[2:0], start_position[34:3], end_position[66:35],
  // duration_ticks[82:67], zero fill[87:83].
  input  logic [87:0] in_tdata,
  // Fields from bit 0: operation[1:0].
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: axis_res[2:0], active[3], finished[4], target_position[36:5],
  // target_velocity[68:37], zero fill[71:69].
  output logic [71:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);

  localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
  localparam logic [AW-1:0] LAST_AXIS = AW'(AXIS_COUNT - 1);

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_NEXT = 4'b0010,
    T_WAIT = 4'b0100,
    T_LOAD = 4'b1000
  } tst_t;

  tst_t state_r, state_nxt;
  logic [AW-1:0] ax_r, ax_nxt;
  logic [15:0] tps_r;

  logic [31:0] start_r [AXIS_COUNT];
  logic [31:0] end_r   [AXIS_COUNT];
  logic [15:0] dur_r   [AXIS_COUNT];
  logic [15:0] elap_r  [AXIS_COUNT];
  logic [31:0] pos_r   [AXIS_COUNT];
  logic [31:0] vel_r   [AXIS_COUNT];
  logic [AXIS_COUNT-1:0] act_r;

  logic        out_valid_r;
  logic [71:0] out_data_r;
  logic        out_last_r;

  op_t         op;
  logic [2:0]  in_axis;
  logic        in_fire, in_axis_ok, load_fire;
  logic [AW-1:0] in_idx;
  logic [15:0] elap_inc, e_clamp;
  logic        eval_start, eval_done;
  req_t        eval_req;
  res_t        eval_res;
  logic        fin;

  assign op         = op_t'(in_tuser);
  assign in_axis    = in_tdata[2:0];
  assign in_idx     = in_axis[AW-1:0];
  assign in_axis_ok = (32'(in_axis) < AXIS_COUNT);
  assign in_tready  = (state_r == T_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign load_fire  = (state_r == T_LOAD) && (!out_valid_r || out_tready);

  // Elapsed count saturates at its top value.
  assign elap_inc   = (elap_r[ax_r] == 16'hFFFF) ? 16'hFFFF : elap_r[ax_r] + 16'd1;
  assign e_clamp    = (elap_inc > dur_r[ax_r]) ? dur_r[ax_r] : elap_inc;
  assign eval_start = (state_r == T_NEXT) && act_r[ax_r];

  assign eval_req.start_pos = start_r[ax_r];
  assign eval_req.end_pos   = end_r[ax_r];
  assign eval_req.dur       = dur_r[ax_r];
  assign eval_req.elap      = e_clamp;

  mqt_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .start (eval_start),
    .req   (eval_req),
    .tps   (tps_r),
    .done  (eval_done),
    .res   (eval_res)
  );

  // Sequencer over the axes of a tick.
  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    unique case (state_r)
      T_IDLE: begin
        if (in_fire && op == OP_TICK) begin
          ax_nxt    = '0;
          state_nxt = T_NEXT;
        end
      end
      T_NEXT: begin
        state_nxt = act_r[ax_r] ? T_WAIT : T_LOAD;
      end
      T_WAIT: begin
        if (eval_done) begin
          state_nxt = T_LOAD;
        end
      end
      T_LOAD: begin
        if (load_fire) begin
          if (ax_r == LAST_AXIS) begin
            state_nxt = T_IDLE;
          end else begin
            ax_nxt    = ax_r + AW'(1);
            state_nxt = T_NEXT;
          end
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      ax_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ax_r    <= ax_nxt;
    end
  end

  // Tick-rate register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      tps_r <= cfg_data;
    end
  end

  // Per-axis state: loaded on start, advanced during a tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        start_r[i] <= 32'd0;
        end_r[i]   <= 32'd0;
        dur_r[i]   <= 16'd0;
        elap_r[i]  <= 16'd0;
        pos_r[i]   <= 32'd0;
        vel_r[i]   <= 32'd0;
      end
      act_r <= '0;
    end else begin
      if (in_fire && in_axis_ok && op == OP_START) begin
        start_r[in_idx] <= in_tdata[34:3];
        end_r[in_idx]   <= in_tdata[66:35];
        dur_r[in_idx]   <= in_tdata[82:67];
        elap_r[in_idx]  <= 16'd0;
        pos_r[in_idx]   <= in_tdata[34:3];
        vel_r[in_idx]   <= 32'd0;
        act_r[in_idx]   <= 1'b1;
      end
      if (in_fire && in_axis_ok && op == OP_STOP) begin
        act_r[in_idx] <= 1'b0;
      end
      if (eval_start) begin
        elap_r[ax_r] <= elap_inc;
      end
      if (state_r == T_WAIT && eval_done) begin
        pos_r[ax_r] <= eval_res.position;
        vel_r[ax_r] <= eval_res.velocity;
      end
    end
  end

  assign fin = act_r[ax_r] && (elap_r[ax_r] >= dur_r[ax_r]);

  // Output register: holds one result until the transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      out_data_r <= {3'd0, vel_r[ax_r], pos_r[ax_r], fin, act_r[ax_r], 3'(ax_r)};
      out_last_r <= (ax_r == LAST_AXIS);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // The serial unit only finishes while the sequencer waits for it.
  `MQT_ASSERT_IMP(a_done_in_wait, eval_done, state_r == T_WAIT)
  // Loading the final axis closes the tick.
  `MQT_ASSERT_NXT(a_last_to_idle, load_fire && ax_r == LAST_AXIS, state_r == T_IDLE)
  // A loaded result is always offered on the next cycle.
  `MQT_ASSERT_NXT(a_load_valid, load_fire, out_tvalid)
  // No input is taken while a tick is in progress.
  `MQT_ASSERT_IMP(a_no_in_busy, state_r == T_WAIT || state_r == T_LOAD, !in_tready)

endmodule

// ===== src/mqt_eval.sv =====
module mqt_eval
  import mqt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  req_t        req,
  input  logic [15:0] tps,
  output logic        done,
  output res_t        res
);

  typedef enum logic [11:0] {
    E_IDLE = 12'b000000000001,
    E_TAU  = 12'b000000000010,
    E_T2   = 12'b000000000100,
    E_T3   = 12'b000000001000,
    E_T4   = 12'b000000010000,
    E_T5   = 12'b000000100000,
    E_POLY = 12'b000001000000,
    E_POS  = 12'b000010000000,
    E_DSV  = 12'b000100000000,
    E_TPS  = 12'b001000000000,
    E_VEL  = 12'b010000000000,
    E_DONE = 12'b100000000000
  } est_t;

  localparam logic [5:0] MUL_LAST = 6'd25;
  localparam logic [5:0] DIV_LAST = 6'd50;

  est_t state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [74:0] p_r, p_nxt;
  logic [58:0] a_r, a_nxt;
  logic [25:0] b_r, b_nxt;
  logic [50:0] n_r, n_nxt;
  logic [15:0] r_r, r_nxt;
  logic [15:0] d_r, d_nxt;
  logic [24:0] tau_r, tau_nxt, t2_r, t2_nxt, t3_r, t3_nxt, t4_r, t4_nxt, t5_r, t5_nxt;
  logic [24:0] s_r, s_nxt;
  logic [25:0] ds_r, ds_nxt;
  logic [31:0] q0_r, q0_nxt, pos_r, pos_nxt, vel_r, vel_nxt;
  logic [32:0] mdq_r, mdq_nxt;
  logic        neg_r, neg_nxt;
  logic [15:0] tps_r, tps_nxt;

  // Serial step datapath: one multiplier bit and one quotient bit per cycle.
  logic [74:0] p_step;
  logic [16:0] rr;
  logic        ge;
  logic [15:0] r_step;
  logic [50:0] n_step;
  logic signed [32:0] dq;
  logic signed [31:0] t2s, t3s, t4s, t5s, s_raw, ds_raw;
  logic signed [58:0] sm, step_sh;

  assign p_step = {p_r[73:0], 1'b0} + (b_r[25] ? 75'(a_r) : 75'd0);
  assign rr     = {r_r, n_r[50]};
  assign ge     = rr >= {1'b0, d_r};
  assign r_step = ge ? 16'(rr - {1'b0, d_r}) : rr[15:0];
  assign n_step = {n_r[49:0], ge};

  assign dq  = $signed({req.end_pos[31], req.end_pos}) -
               $signed({req.start_pos[31], req.start_pos});
  assign t2s = $signed({7'd0, t2_r});
  assign t3s = $signed({7'd0, t3_r});
  assign t4s = $signed({7'd0, t4_r});
  assign t5s = $signed({7'd0, t5_r});
  assign s_raw  = C10 * t3s - C15 * t4s + C6 * t5s;
  assign ds_raw = C30 * t2s - C60 * t3s + C30 * t4s;

  // Position step is the product shifted right with rounding towards minus infinity.
  assign sm      = neg_r ? -$signed({1'b0, p_step[57:0]}) : $signed({1'b0, p_step[57:0]});
  assign step_sh = sm >>> 24;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    p_nxt     = p_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    n_nxt     = n_r;
    r_nxt     = r_r;
    d_nxt     = d_r;
    tau_nxt   = tau_r;
    t2_nxt    = t2_r;
    t3_nxt    = t3_r;
    t4_nxt    = t4_r;
    t5_nxt    = t5_r;
    s_nxt     = s_r;
    ds_nxt    = ds_r;
    q0_nxt    = q0_r;
    pos_nxt   = pos_r;
    vel_nxt   = vel_r;
    mdq_nxt   = mdq_r;
    neg_nxt   = neg_r;
    tps_nxt   = tps_r;
    unique case (state_r)
      E_IDLE: begin
        if (start) begin
          tps_nxt = tps;
          q0_nxt  = req.start_pos;
          neg_nxt = dq[32];
          mdq_nxt = dq[32] ? 33'(-dq) : 33'(dq);
          if (req.dur == 16'd0) begin
            pos_nxt   = req.end_pos;
            vel_nxt   = 32'd0;
            state_nxt = E_DONE;
          end else begin
            n_nxt     = {11'd0, req.elap, 24'd0};
            r_nxt     = 16'd0;
            d_nxt     = req.dur;
            cnt_nxt   = DIV_LAST;
            state_nxt = E_TAU;
          end
        end
      end
      E_TAU, E_VEL: begin
        n_nxt   = n_step;
        r_nxt   = r_step;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          if (state_r == E_TAU) begin
            tau_nxt   = n_step[24:0];
            a_nxt     = 59'(n_step[24:0]);
            b_nxt     = 26'(n_step[24:0]);
            p_nxt     = 75'd0;
            cnt_nxt   = MUL_LAST;
            state_nxt = E_T2;
          end else begin
            if (neg_r) begin
              vel_nxt = (n_step >= 51'h8000_0000) ? 32'h8000_0000 : 32'(-n_step[31:0]);
            end else begin
              vel_nxt = (n_step > 51'h7FFF_FFFF) ? 32'h7FFF_FFFF : n_step[31:0];
            end
            state_nxt = E_DONE;
          end
        end
      end
      E_T2, E_T3, E_T4, E_T5, E_POS, E_DSV, E_TPS: begin
        p_nxt   = p_step;
        b_nxt   = {b_r[24:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          p_nxt   = 75'd0;
          cnt_nxt = MUL_LAST;
          b_nxt   = 26'(tau_r);
          case (state_r)
            E_T2: begin
              t2_nxt    = p_step[48:24];
              a_nxt     = 59'(p_step[48:24]);
              state_nxt = E_T3;
            end
            E_T3: begin
              t3_nxt    = p_step[48:24];
              a_nxt     = 59'(p_step[48:24]);
              state_nxt = E_T4;
            end
            E_T4: begin
              t4_nxt    = p_step[48:24];
              a_nxt     = 59'(p_step[48:24]);
              state_nxt = E_T5;
            end
            E_T5: begin
              t5_nxt    = p_step[48:24];
              state_nxt = E_POLY;
            end
            E_POS: begin
              pos_nxt   = q0_r + step_sh[31:0];
              a_nxt     = 59'(mdq_r);
              b_nxt     = ds_r;
              state_nxt = E_DSV;
            end
            E_DSV: begin
              a_nxt     = p_step[58:0];
              b_nxt     = 26'(tps_r);
              state_nxt = E_TPS;
            end
            default: begin
              n_nxt     = p_step[74:24];
              r_nxt     = 16'd0;
              cnt_nxt   = DIV_LAST;
              state_nxt = E_VEL;
            end
          endcase
        end
      end
      E_POLY: begin
        if (s_raw < 0) begin
          s_nxt = 25'd0;
        end else if (s_raw > ONE_Q24) begin
          s_nxt = ONE_Q24[24:0];
        end else begin
          s_nxt = s_raw[24:0];
        end
        ds_nxt    = (ds_raw < 0) ? 26'd0 : ds_raw[25:0];
        a_nxt     = 59'(mdq_r);
        b_nxt     = 26'(s_nxt);
        p_nxt     = 75'd0;
        cnt_nxt   = MUL_LAST;
        state_nxt = E_POS;
      end
      E_DONE: begin
        state_nxt = E_IDLE;
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      cnt_r   <= 6'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    n_r   <= n_nxt;
    r_r   <= r_nxt;
    d_r   <= d_nxt;
    tau_r <= tau_nxt;
    t2_r  <= t2_nxt;
    t3_r  <= t3_nxt;
    t4_r  <= t4_nxt;
    t5_r  <= t5_nxt;
    s_r   <= s_nxt;
    ds_r  <= ds_nxt;
    q0_r  <= q0_nxt;
    pos_r <= pos_nxt;
    vel_r <= vel_nxt;
    mdq_r <= mdq_nxt;
    neg_r <= neg_nxt;
    tps_r <= tps_nxt;
  end

  assign done         = (state_r == E_DONE);
  assign res.position = pos_r;
  assign res.velocity = vel_r;

endmodule

// ===== dv/mqt_trajectory_checker.sv =====
module mqt_trajectory_checker
  import mqt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [87:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] cfg_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  output int          fail_count,
  output int          targets_due
);

  localparam int NUM_AXES = 6;

  // One axis report as the block should send it.
  typedef struct {
    logic [2:0]  axis;
    logic        active;
    logic        finished;
    logic [31:0] position;
    logic [31:0] velocity;
    logic        last;
  } axis_report_t;

  logic [31:0] from_pos [NUM_AXES];
  logic [31:0] to_pos   [NUM_AXES];
  logic [15:0] span     [NUM_AXES];
  logic [15:0] elapsed  [NUM_AXES];
  logic [31:0] cur_pos  [NUM_AXES];
  logic [31:0] cur_vel  [NUM_AXES];
  logic        running  [NUM_AXES];
  logic [15:0] tick_rate;
  axis_report_t due_reports[$];

  // Re-evaluate the quintic profile of one axis.
  task automatic update_target(input int a);
    longint q0, qf, dq, s, ds, prod, step, vel;
    logic [63:0] dur, e, tau, t2, t3, t4, t5, mdq, m, hi, lo, b, v;
    q0 = longint'(signed'(from_pos[a]));
    qf = longint'(signed'(to_pos[a]));
    dur = 64'(span[a]);
    if (dur == 0) begin
      cur_pos[a] = to_pos[a];
      cur_vel[a] = '0;
      return;
    end
    e = 64'(elapsed[a]);
    if (e > dur) e = dur;
    tau = (e << 24) / dur;
    t2 = (tau * tau) >> 24;
    t3 = (t2 * tau) >> 24;
    t4 = (t3 * tau) >> 24;
    t5 = (t4 * tau) >> 24;
    s = 10 * longint'(t3) - 15 * longint'(t4) + 6 * longint'(t5);
    if (s < 0) s = 0;
    if (s > 64'sd16777216) s = 64'sd16777216;
    ds = 30 * longint'(t2) - 60 * longint'(t3) + 30 * longint'(t4);
    if (ds < 0) ds = 0;
    dq = qf - q0;
    prod = dq * s;
    // Negative steps round towards minus infinity.
    if (prod >= 0) step = prod >>> 24;
    else step = -longint'((64'(-prod) + 64'd16777215) >> 24);
    cur_pos[a] = 32'(q0 + step);
    mdq = (dq < 0) ? 64'(-dq) : 64'(dq);
    m = mdq * 64'(ds);
    hi = m >> 24;
    lo = m & 64'hFF_FFFF;
    b = hi * 64'(tick_rate) + ((lo * 64'(tick_rate)) >> 24);
    v = b / dur;
    if (dq < 0) vel = (v >= 64'h8000_0000) ? -64'sh8000_0000 : -longint'(v);
    else vel = (v > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(v);
    cur_vel[a] = 32'(vel);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Track configuration and input transfers, and compare each result transfer.
  always @(posedge clk) begin
    op_t op;
    logic [2:0] ax;
    axis_report_t rep;
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        from_pos[i] = '0; to_pos[i] = '0; span[i] = '0; elapsed[i] = '0;
        cur_pos[i] = '0; cur_vel[i] = '0; running[i] = 1'b0;
      end
      tick_rate = 16'd1000;
      due_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) tick_rate = cfg_data;
      if (out_tvalid && out_tready) begin
        if (due_reports.size() == 0) begin
          $error("result transfer with no result due: %h", out_tdata);
          fail_count++;
        end else begin
          rep = due_reports.pop_front();
          check_field("axis_res", 32'(rep.axis), 32'(out_tdata[2:0]));
          check_field("active", 32'(rep.active), 32'(out_tdata[3]));
          check_field("finished", 32'(rep.finished), 32'(out_tdata[4]));
          check_field("target_position", rep.position, out_tdata[36:5]);
          check_field("target_velocity", rep.velocity, out_tdata[68:37]);
          check_field("last", 32'(rep.last), 32'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) begin
        op = op_t'(in_tuser);
        ax = in_tdata[2:0];
        case (op)
          OP_START: begin
            if (ax < NUM_AXES) begin
              from_pos[ax] = in_tdata[34:3];
              to_pos[ax] = in_tdata[66:35];
              span[ax] = in_tdata[82:67];
              elapsed[ax] = '0;
              cur_pos[ax] = in_tdata[34:3];
              cur_vel[ax] = '0;
              running[ax] = 1'b1;
            end
          end
          OP_STOP: begin
            if (ax < NUM_AXES) running[ax] = 1'b0;
          end
          OP_TICK: begin
            for (int i = 0; i < NUM_AXES; i++) begin
              if (running[i]) begin
                if (elapsed[i] != 16'hFFFF) elapsed[i]++;
                update_target(i);
              end
            end
            for (int i = 0; i < NUM_AXES; i++) begin
              rep.axis = 3'(i);
              rep.active = running[i];
              rep.finished = running[i] && (elapsed[i] >= span[i]);
              rep.position = cur_pos[i];
              rep.velocity = cur_vel[i];
              rep.last = (i == NUM_AXES - 1);
              due_reports.push_back(rep);
            end
          end
          default: ;
        endcase
      end
    end
    targets_due = due_reports.size();
  end

  initial fail_count = 0;

endmodule

// ===== dv/tb_multi_axis_quintic_trajectory_unit.sv =====
module tb_multi_axis_quintic_trajectory_unit;
  import mqt_pkg::*;

  logic        clk;
  logic        rst_n;
  logic [87:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] out_tdata;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] cfg_data;
  logic        cfg_valid;
  logic        cfg_ready;
  int          fail_count;
  int          targets_due;
  bit          steady;
  int          holdoff_asked;
  int          holdoff_served;
  int          holdoff_left;

  multi_axis_quintic_trajectory_unit dut (.*);

  mqt_trajectory_checker checker_i (.*);

  always #5 clk = ~clk;

  // Result side: random back-pressure, plus long hold-offs on request.
  always @(posedge clk) begin
    if (holdoff_asked != holdoff_served) begin
      holdoff_served = holdoff_asked;
      holdoff_left = 3000;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_tready <= 1'b0;
    end else if (steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 37);
    end
  end

  initial begin
    #30_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one item and hold it until the transfer, then maybe idle.
  task automatic offer(input op_t op, input logic [2:0] ax, input logic [31:0] sp,
                       input logic [31:0] ep, input logic [15:0] dur);
    in_tuser <= op;
    in_tdata <= {5'b0, dur, ep, sp, ax};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!steady && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic tick();
    offer(OP_TICK, 3'($urandom), $urandom, $urandom, 16'($urandom));
  endtask

  // Wait until every due result has come, then let the block settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (targets_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_tick_rate(input logic [15:0] rate);
    cfg_data <= rate;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly ticks and moves in random order, with some stops and unknown operations.
  task automatic random_phase(input int n);
    int r;
    logic [31:0] sp;
    logic [15:0] dur;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      sp = $urandom;
      if ($urandom_range(9) < 1) dur = '0;
      else if ($urandom_range(9) < 8) dur = 16'($urandom_range(1, 12));
      else if ($urandom_range(9) < 7) dur = 16'($urandom_range(13, 400));
      else dur = 16'($urandom);
      if (r < 35)
        offer(OP_START, 3'($urandom_range(0, 7)), sp,
              ($urandom_range(1) != 0) ? $urandom : sp + 32'($urandom_range(0, 1 << 20)),
              dur);
      else if (r < 45) offer(OP_STOP, 3'($urandom_range(0, 7)), $urandom, $urandom, dur);
      else if (r < 95) tick();
      else offer(OP_NONE, 3'($urandom), $urandom, $urandom, 16'($urandom));
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tdata = '0;
    in_tuser = OP_NONE;
    in_tvalid = 1'b0;
    out_tready = 1'b0;
    cfg_data = '0;
    cfg_valid = 1'b0;
    steady = 1'b0;
    holdoff_asked = 0;
    holdoff_served = 0;
    holdoff_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of position and duration at the highest tick rate.
    set_tick_rate(16'hFFFF);
    tick();
    offer(OP_START, 3'd0, 32'h8000_0000, 32'h7FFF_FFFF, 16'd2);
    offer(OP_START, 3'd1, 32'h7FFF_FFFF, 32'h8000_0000, 16'd3);
    offer(OP_START, 3'd2, 32'h0001_0000, 32'h0005_0000, 16'd0);
    offer(OP_START, 3'd3, 32'h0000_0000, 32'hFFFF_FFFF, 16'd1);
    offer(OP_START, 3'd4, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF);
    offer(OP_START, 3'd5, 32'h1234_5678, 32'h1234_5678, 16'd4);
    offer(OP_START, 3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    offer(OP_STOP, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    offer(OP_NONE, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    repeat (4) tick();
    offer(OP_STOP, 3'd4, '0, '0, '0);
    tick();
    offer(OP_START, 3'd4, 32'h0000_0000, 32'h0010_0000, 16'd5);
    tick();
    drain();

    // The result side holds off while ticks keep coming.
    steady = 1'b1;
    holdoff_asked++;
    repeat (8) tick();
    drain();
    steady = 1'b0;

    set_tick_rate(16'($urandom_range(1, 65535)));
    random_phase(60);
    drain();
    set_tick_rate(16'd1);
    random_phase(40);
    drain();
    set_tick_rate(16'd0);
    tick();
    drain();
    steady = 1'b1;
    set_tick_rate(16'd1000);
    random_phase(40);
    steady = 1'b0;
    random_phase(40);
    drain();
    repeat (50) @(posedge clk);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
